// ===== rtl/ptcq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcq_pkg
// Shared types and codes for the pan/tilt tracking command queue.
// ----------------------------------------------------------------------------
package ptcq_pkg;

	// input item kinds (carried on s_tuser)
	localparam logic [1:0] ACT_TRACK  = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_MANUAL = 2'd2;
	localparam logic [1:0] ACT_STOP   = 2'd3;

	// camera head command codes
	localparam logic [3:0] CMD_PAN_RIGHT = 4'd0;
	localparam logic [3:0] CMD_PAN_LEFT  = 4'd1;
	localparam logic [3:0] CMD_PAN_STOP  = 4'd2;
	localparam logic [3:0] CMD_TILT_UP   = 4'd3;
	localparam logic [3:0] CMD_TILT_DOWN = 4'd4;
	localparam logic [3:0] CMD_TILT_STOP = 4'd5;
	localparam logic [3:0] CMD_TELE      = 4'd6;
	localparam logic [3:0] CMD_WIDE      = 4'd7;
	localparam logic [3:0] CMD_ZOOM_STOP = 4'd8;
	localparam logic [3:0] CMD_PRESET    = 4'd9;
	localparam logic [3:0] CMD_HOME      = 4'd10;

	// axis motion state
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd2;

	localparam logic [3:0] SPEED_MAX = 4'd9;

	// configuration register indexes
	localparam logic [2:0] REG_CENTER_X       = 3'd0;
	localparam logic [2:0] REG_CENTER_Y       = 3'd1;
	localparam logic [2:0] REG_DEAD_ZONE      = 3'd2;
	localparam logic [2:0] REG_SPEED_LEVELS   = 3'd3;
	localparam logic [2:0] REG_ISSUE_INTERVAL = 3'd4;

	typedef struct packed {
		logic [3:0] cmd;
		logic [3:0] spd;
	} q_entry_t;

	typedef struct packed {
		logic     clear;
		logic     push;
		logic     pop;
		q_entry_t push_data;
	} q_ctrl_t;

endpackage

// ===== rtl/pan_tilt_tracking_command_queue.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_tracking_command_queue
// Tracking-to-PTZ command generator with a ring command queue and tick-paced
// issue.
// ----------------------------------------------------------------------------
// One item at a time: s_tready is high only while the sequencer is idle. A
// tracking sample makes up to two runs (pan, then tilt) of the shared 16-step
// restoring divider, plus setup and queue update states. A tick that issues a
// command goes on to ST_TICK_OUT for the registered queue read, and waits
// there for the result register to drain. A stop request runs the queue clear
// and stop states; a manual command may run them before its own push.
// The result register lets new items in while an issued command still waits
// on m_tready. Queue entries need no clearing after reset.
// ----------------------------------------------------------------------------
module pan_tilt_tracking_command_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_pos[11:0], y_pos[23:12], manual_command[27:24],
	                               // manual_speed[31:28]
	input  logic [1:0]  s_tuser,   // action[1:0]
	// issued commands
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // command[3:0], speed[7:4]
);

	typedef enum logic [12:0] {
		ST_IDLE      = 13'b0000000000001,
		ST_TRK_SETUP = 13'b0000000000010,
		ST_TRK_START = 13'b0000000000100,
		ST_TRK_DIV   = 13'b0000000001000,
		ST_TRK_APPLY = 13'b0000000010000,
		ST_TICK      = 13'b0000000100000,
		ST_TICK_OUT  = 13'b0000001000000,
		ST_MAN       = 13'b0000010000000,
		ST_MAN_PUSH  = 13'b0000100000000,
		ST_STOP_CLR  = 13'b0001000000000,
		ST_STOP_PAN  = 13'b0010000000000,
		ST_STOP_TILT = 13'b0100000000000,
		ST_STOP_ZOOM = 13'b1000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [11:0] center_x_q;
	logic [11:0] center_y_q;
	logic [11:0] dead_zone_q;
	logic [3:0]  speed_levels_q;
	logic [15:0] issue_interval_q;

	// captured item
	logic [1:0]  action_q;
	logic [11:0] x_pos_q;
	logic [11:0] y_pos_q;
	logic [3:0]  mcmd_q;
	logic [3:0]  mspd_q;

	// tracking state
	logic [1:0]  pan_req_q;
	logic [1:0]  tilt_req_q;
	logic [3:0]  pan_last_q;
	logic [3:0]  tilt_last_q;
	logic [1:0]  pan_issued_q;
	logic [1:0]  tilt_issued_q;
	logic [1:0]  zoom_issued_q;
	logic [15:0] ticks_q;

	// per-axis working registers
	logic        axis_q;      // 0 pan, 1 tilt
	logic [1:0]  dir_q;
	logic        sat_q;
	logic        zero_q;
	logic [15:0] num_q;
	logic [11:0] den_q;
	logic [3:0]  spd_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  out_cmd_q;
	logic [3:0]  out_spd_q;

	ptcq_pkg::q_ctrl_t  q_ctrl;
	ptcq_pkg::q_entry_t q_pop_data;
	logic               q_empty;

	logic        div_done;
	logic [15:0] div_quot;

	ptcq_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (q_ctrl),
		.empty   (q_empty),
		.pop_data(q_pop_data)
	);

	ptcq_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_TRK_START && !sat_q && !zero_q),
		.num     (num_q),
		.den     (den_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	// axis geometry
	logic signed [12:0] pos_s, ctr_s, dz_s, d_s, mag_s, mdiff_s, den_s;
	logic [15:0]        num_c;

	always_comb begin
		pos_s   = axis_q ? $signed({1'b0, y_pos_q}) : $signed({1'b0, x_pos_q});
		ctr_s   = axis_q ? $signed({1'b0, center_y_q}) : $signed({1'b0, center_x_q});
		dz_s    = $signed({1'b0, dead_zone_q});
		d_s     = pos_s - ctr_s;
		mag_s   = d_s[12] ? -d_s : d_s;
		mdiff_s = mag_s - dz_s;
		den_s   = ctr_s - dz_s;
		num_c   = {4'b0, mdiff_s[11:0]} * {12'b0, speed_levels_q};
	end

	// axis decision
	logic [1:0] req_cur;
	logic [3:0] last_cur;
	logic [3:0] base_cmd;
	logic       trk_push;
	logic [3:0] trk_cmd;
	logic [3:0] trk_spd;

	always_comb begin
		req_cur  = axis_q ? tilt_req_q : pan_req_q;
		last_cur = axis_q ? tilt_last_q : pan_last_q;
		base_cmd = axis_q ? ptcq_pkg::CMD_TILT_UP : ptcq_pkg::CMD_PAN_RIGHT;
		trk_push = 1'b0;
		trk_cmd  = base_cmd;
		trk_spd  = spd_q;
		unique case (dir_q)
			ptcq_pkg::DIR_POS: begin
				trk_push = req_cur != ptcq_pkg::DIR_POS || last_cur != spd_q;
			end
			ptcq_pkg::DIR_NEG: begin
				trk_push = req_cur != ptcq_pkg::DIR_NEG || last_cur != spd_q;
				trk_cmd  = base_cmd + 4'd1;
			end
			default: begin
				trk_push = req_cur != ptcq_pkg::DIR_STOP;
				trk_cmd  = base_cmd + 4'd2;
				trk_spd  = '0;
			end
		endcase
	end

	// tick pacing
	logic [15:0] ticks_inc;
	logic        tick_fire;
	logic        out_free;
	logic        man_plain;

	assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign tick_fire = !q_empty && ticks_inc >= issue_interval_q;
	assign out_free  = !out_valid_q || m_tready;
	// these manual codes go in without a full stop first
	assign man_plain = mcmd_q == ptcq_pkg::CMD_PAN_STOP || mcmd_q == ptcq_pkg::CMD_TILT_STOP ||
	                   mcmd_q == ptcq_pkg::CMD_ZOOM_STOP || mcmd_q == ptcq_pkg::CMD_PRESET;

	always_comb begin
		q_ctrl           = '0;
		q_ctrl.push_data = '0;
		unique case (state_q)
			ST_TRK_APPLY: begin
				q_ctrl.push      = trk_push;
				q_ctrl.push_data = '{cmd: trk_cmd, spd: trk_spd};
			end
			ST_TICK:      q_ctrl.pop = tick_fire;
			ST_MAN_PUSH: begin
				q_ctrl.push      = 1'b1;
				q_ctrl.push_data = '{cmd: mcmd_q,
				                     spd: (mspd_q > ptcq_pkg::SPEED_MAX) ? ptcq_pkg::SPEED_MAX
				                                                         : mspd_q};
			end
			ST_STOP_CLR:  q_ctrl.clear = 1'b1;
			ST_STOP_PAN: begin
				q_ctrl.push      = pan_issued_q != ptcq_pkg::DIR_STOP;
				q_ctrl.push_data = '{cmd: ptcq_pkg::CMD_PAN_STOP, spd: 4'd0};
			end
			ST_STOP_TILT: begin
				q_ctrl.push      = tilt_issued_q != ptcq_pkg::DIR_STOP;
				q_ctrl.push_data = '{cmd: ptcq_pkg::CMD_TILT_STOP, spd: 4'd0};
			end
			ST_STOP_ZOOM: begin
				q_ctrl.push      = zoom_issued_q != ptcq_pkg::DIR_STOP;
				q_ctrl.push_data = '{cmd: ptcq_pkg::CMD_ZOOM_STOP, spd: 4'd0};
			end
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q       <= 12'd320;
			center_y_q       <= 12'd240;
			dead_zone_q      <= 12'd40;
			speed_levels_q   <= 4'd7;
			issue_interval_q <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptcq_pkg::REG_CENTER_X:       center_x_q       <= cfg_wdata[11:0];
				ptcq_pkg::REG_CENTER_Y:       center_y_q       <= cfg_wdata[11:0];
				ptcq_pkg::REG_DEAD_ZONE:      dead_zone_q      <= cfg_wdata[11:0];
				ptcq_pkg::REG_SPEED_LEVELS:   speed_levels_q   <= cfg_wdata[3:0];
				ptcq_pkg::REG_ISSUE_INTERVAL: issue_interval_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured item and axis working values
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_q <= s_tuser;
			x_pos_q  <= s_tdata[11:0];
			y_pos_q  <= s_tdata[23:12];
			mcmd_q   <= s_tdata[27:24];
			mspd_q   <= s_tdata[31:28];
		end
		if (state_q == ST_TRK_SETUP) begin
			if (d_s > dz_s)       dir_q <= ptcq_pkg::DIR_POS;
			else if (d_s < -dz_s) dir_q <= ptcq_pkg::DIR_NEG;
			else                  dir_q <= ptcq_pkg::DIR_STOP;
			sat_q  <= den_s <= 13'sd0;
			zero_q <= mdiff_s <= 13'sd0;
			num_q  <= num_c;
			den_q  <= den_s[11:0];
		end
		if (state_q == ST_TRK_START) begin
			if (sat_q)       spd_q <= ptcq_pkg::SPEED_MAX;
			else if (zero_q) spd_q <= '0;
		end
		if (state_q == ST_TRK_DIV && div_done) begin
			spd_q <= (div_quot > 16'(ptcq_pkg::SPEED_MAX)) ? ptcq_pkg::SPEED_MAX : div_quot[3:0];
		end
		if (state_q == ST_TICK_OUT && out_free) begin
			out_cmd_q <= q_pop_data.cmd;
			out_spd_q <= q_pop_data.spd;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			axis_q        <= 1'b0;
			pan_req_q     <= ptcq_pkg::DIR_STOP;
			tilt_req_q    <= ptcq_pkg::DIR_STOP;
			pan_last_q    <= '0;
			tilt_last_q   <= '0;
			pan_issued_q  <= ptcq_pkg::DIR_STOP;
			tilt_issued_q <= ptcq_pkg::DIR_STOP;
			zoom_issued_q <= ptcq_pkg::DIR_STOP;
			ticks_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// a reload in ST_TICK_OUT takes the place of the clear
			if (m_tvalid && m_tready && !(state_q == ST_TICK_OUT && out_free))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						axis_q <= 1'b0;
						unique case (s_tuser)
							ptcq_pkg::ACT_TRACK:  state_q <= ST_TRK_SETUP;
							ptcq_pkg::ACT_TICK:   state_q <= ST_TICK;
							ptcq_pkg::ACT_MANUAL: state_q <= ST_MAN;
							default:              state_q <= ST_STOP_CLR;
						endcase
					end
				end
				ST_TRK_SETUP: state_q <= ST_TRK_START;
				ST_TRK_START: state_q <= (sat_q || zero_q) ? ST_TRK_APPLY : ST_TRK_DIV;
				ST_TRK_DIV:   if (div_done) state_q <= ST_TRK_APPLY;
				ST_TRK_APPLY: begin
					if (trk_push) begin
						if (axis_q) begin
							tilt_req_q <= dir_q;
							if (dir_q != ptcq_pkg::DIR_STOP) tilt_last_q <= spd_q;
						end else begin
							pan_req_q <= dir_q;
							if (dir_q != ptcq_pkg::DIR_STOP) pan_last_q <= spd_q;
						end
					end
					axis_q  <= 1'b1;
					state_q <= axis_q ? ST_IDLE : ST_TRK_SETUP;
				end
				ST_TICK: begin
					ticks_q <= tick_fire ? '0 : ticks_inc;
					state_q <= tick_fire ? ST_TICK_OUT : ST_IDLE;
				end
				ST_TICK_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						unique case (q_pop_data.cmd)
							ptcq_pkg::CMD_PAN_RIGHT: pan_issued_q  <= ptcq_pkg::DIR_POS;
							ptcq_pkg::CMD_PAN_LEFT:  pan_issued_q  <= ptcq_pkg::DIR_NEG;
							ptcq_pkg::CMD_PAN_STOP:  pan_issued_q  <= ptcq_pkg::DIR_STOP;
							ptcq_pkg::CMD_TILT_UP:   tilt_issued_q <= ptcq_pkg::DIR_POS;
							ptcq_pkg::CMD_TILT_DOWN: tilt_issued_q <= ptcq_pkg::DIR_NEG;
							ptcq_pkg::CMD_TILT_STOP: tilt_issued_q <= ptcq_pkg::DIR_STOP;
							ptcq_pkg::CMD_TELE:      zoom_issued_q <= ptcq_pkg::DIR_POS;
							ptcq_pkg::CMD_WIDE:      zoom_issued_q <= ptcq_pkg::DIR_NEG;
							ptcq_pkg::CMD_ZOOM_STOP: zoom_issued_q <= ptcq_pkg::DIR_STOP;
							default: ;
						endcase
						state_q <= ST_IDLE;
					end
				end
				ST_MAN: begin
					if (mcmd_q > ptcq_pkg::CMD_HOME) state_q <= ST_IDLE;
					else if (man_plain)              state_q <= ST_MAN_PUSH;
					else                             state_q <= ST_STOP_CLR;
				end
				ST_MAN_PUSH:  state_q <= ST_IDLE;
				ST_STOP_CLR:  state_q <= ST_STOP_PAN;
				ST_STOP_PAN:  state_q <= ST_STOP_TILT;
				ST_STOP_TILT: state_q <= ST_STOP_ZOOM;
				ST_STOP_ZOOM: begin
					pan_req_q     <= ptcq_pkg::DIR_STOP;
					tilt_req_q    <= ptcq_pkg::DIR_STOP;
					pan_last_q    <= '0;
					tilt_last_q   <= '0;
					pan_issued_q  <= ptcq_pkg::DIR_STOP;
					tilt_issued_q <= ptcq_pkg::DIR_STOP;
					zoom_issued_q <= ptcq_pkg::DIR_STOP;
					state_q <= (action_q == ptcq_pkg::ACT_MANUAL) ? ST_MAN_PUSH : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_spd_q, out_cmd_q};

endmodule

// ===== rtl/ptcq_divider.sv =====
// ----------------------------------------------------------------------------
// ptcq_divider
// Restoring radix-2 divider, 16-bit dividend by 12-bit divisor, one quotient
// bit per cycle. done pulses high for one cycle together with the final quotient.
// ----------------------------------------------------------------------------
module ptcq_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [11:0] den,
	output logic        done,
	output logic [15:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] quo_q;
	logic [11:0] den_q;
	logic [11:0] rem_q;
	logic [12:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[15]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[14:0], fits};
			rem_q <= fits ? 12'(trial - {1'b0, den_q}) : trial[11:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/ptcq_queue.sv =====
// ----------------------------------------------------------------------------
// ptcq_queue
// Ring queue of commands. Holds up to QUEUE_DEPTH-1 entries; a push into a
// full queue is dropped. Pop advances the head and registers that entry.
// ----------------------------------------------------------------------------
module ptcq_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ptcq_pkg::q_ctrl_t ctrl,
	output logic              empty,
	output ptcq_pkg::q_entry_t pop_data
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	ptcq_pkg::q_entry_t mem [QUEUE_DEPTH];
	ptcq_pkg::q_entry_t rd_data_q;

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] tail_nxt;
	logic          full;
	logic          do_push;

	assign head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign full     = tail_nxt == head_q;
	assign empty    = head_q == tail_q;
	assign do_push  = ctrl.push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctrl.clear) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (do_push) tail_q <= tail_nxt;
			if (ctrl.pop) head_q <= head_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push && !ctrl.clear) mem[tail_nxt] <= ctrl.push_data;
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) rd_data_q <= mem[head_nxt];
	end

	assign pop_data = rd_data_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pan/tilt tracking command queue. A queue of
// pending items feeds a clocked driver on the input stream. A cycle-free
// predictor of the tracking, ring queue and tick-paced issue logic updates
// on each accepted input transfer and queues the commands that should be
// issued. A clocked monitor checks each output transfer against the oldest
// of them. Phases change the configuration only after the ring has been
// emptied with ticks and every issued command has been seen.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QD            = 16;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] data;
	} item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;

	pan_tilt_tracking_command_queue #(
		.QUEUE_DEPTH(QD)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	item_t              send_fifo[$];
	ptcq_pkg::q_entry_t issue_expect[$];
	item_t              nxt_item;
	ptcq_pkg::q_entry_t want;
	logic               calm        = 1'b0;
	logic               in_xfer     = 1'b0;
	int                 send_gap    = 0;
	int                 stall_gap   = 0;
	int                 n_mismatch  = 0;
	int                 idle_cycles = 0;

	// predicted block state
	logic [11:0]        cx_r, cy_r, dz_r;
	logic [3:0]         lv_r;
	logic [15:0]        iv_r;
	ptcq_pkg::q_entry_t ring [QD];
	logic [3:0]         rd_ptr, wr_ptr;
	logic [1:0]         pan_req, tilt_req;
	logic [3:0]         pan_last, tilt_last;
	logic [1:0]         pan_dir, tilt_dir, zoom_dir;
	logic [15:0]        tick_cnt;

	initial forever #1 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic void ring_push(logic [3:0] c, logic [3:0] s);
		logic [3:0] nxt;
		nxt = wr_ptr + 4'd1;
		if (nxt != rd_ptr) begin
			ring[nxt] = {c, s};
			wr_ptr = nxt;
		end
	endfunction

	function automatic logic [3:0] move_speed(int pos, int ctr);
		int mag, den, q;
		mag = pos - ctr;
		if (mag < 0)
			mag = -mag;
		den = ctr - int'(dz_r);
		if (den <= 0)
			return ptcq_pkg::SPEED_MAX;
		q = (mag - int'(dz_r)) * int'(lv_r) / den;
		if (q < 0)
			q = 0;
		if (q > 9)
			q = 9;
		return 4'(q);
	endfunction

	function automatic void track_axis(input int pos, input int ctr,
			input logic [3:0] c_pos, input logic [3:0] c_neg, input logic [3:0] c_stop,
			inout logic [1:0] req, inout logic [3:0] last);
		int d, dz;
		logic [3:0] spd;
		d = pos - ctr;
		dz = int'(dz_r);
		spd = move_speed(pos, ctr);
		if (d > dz) begin
			if (req != ptcq_pkg::DIR_POS || last != spd) begin
				ring_push(c_pos, spd);
				last = spd;
				req = ptcq_pkg::DIR_POS;
			end
		end else if (d < -dz) begin
			if (req != ptcq_pkg::DIR_NEG || last != spd) begin
				ring_push(c_neg, spd);
				last = spd;
				req = ptcq_pkg::DIR_NEG;
			end
		end else if (req != ptcq_pkg::DIR_STOP) begin
			ring_push(c_stop, 4'd0);
			req = ptcq_pkg::DIR_STOP;
		end
	endfunction

	// flush the ring and stop whatever the head was last told to move
	function automatic void halt_all();
		rd_ptr = '0;
		wr_ptr = '0;
		if (pan_dir != ptcq_pkg::DIR_STOP)
			ring_push(ptcq_pkg::CMD_PAN_STOP, 4'd0);
		if (tilt_dir != ptcq_pkg::DIR_STOP)
			ring_push(ptcq_pkg::CMD_TILT_STOP, 4'd0);
		if (zoom_dir != ptcq_pkg::DIR_STOP)
			ring_push(ptcq_pkg::CMD_ZOOM_STOP, 4'd0);
		pan_req = ptcq_pkg::DIR_STOP;
		tilt_req = ptcq_pkg::DIR_STOP;
		pan_last = '0;
		tilt_last = '0;
		pan_dir = ptcq_pkg::DIR_STOP;
		tilt_dir = ptcq_pkg::DIR_STOP;
		zoom_dir = ptcq_pkg::DIR_STOP;
	endfunction

	function automatic void predict_item(logic [1:0] act, logic [31:0] data);
		logic [3:0] mc, ms;
		ptcq_pkg::q_entry_t e;
		mc = data[27:24];
		ms = data[31:28];
		case (act)
			ptcq_pkg::ACT_TRACK: begin
				track_axis(int'(data[11:0]), int'(cx_r), ptcq_pkg::CMD_PAN_RIGHT,
					ptcq_pkg::CMD_PAN_LEFT, ptcq_pkg::CMD_PAN_STOP, pan_req, pan_last);
				track_axis(int'(data[23:12]), int'(cy_r), ptcq_pkg::CMD_TILT_UP,
					ptcq_pkg::CMD_TILT_DOWN, ptcq_pkg::CMD_TILT_STOP, tilt_req, tilt_last);
			end
			ptcq_pkg::ACT_TICK: begin
				if (tick_cnt != 16'hFFFF)
					tick_cnt = tick_cnt + 16'd1;
				if (rd_ptr != wr_ptr && tick_cnt >= iv_r) begin
					tick_cnt = '0;
					rd_ptr = rd_ptr + 4'd1;
					e = ring[rd_ptr];
					case (e.cmd)
						ptcq_pkg::CMD_PAN_RIGHT: pan_dir = ptcq_pkg::DIR_POS;
						ptcq_pkg::CMD_PAN_LEFT:  pan_dir = ptcq_pkg::DIR_NEG;
						ptcq_pkg::CMD_PAN_STOP:  pan_dir = ptcq_pkg::DIR_STOP;
						ptcq_pkg::CMD_TILT_UP:   tilt_dir = ptcq_pkg::DIR_POS;
						ptcq_pkg::CMD_TILT_DOWN: tilt_dir = ptcq_pkg::DIR_NEG;
						ptcq_pkg::CMD_TILT_STOP: tilt_dir = ptcq_pkg::DIR_STOP;
						ptcq_pkg::CMD_TELE:      zoom_dir = ptcq_pkg::DIR_POS;
						ptcq_pkg::CMD_WIDE:      zoom_dir = ptcq_pkg::DIR_NEG;
						ptcq_pkg::CMD_ZOOM_STOP: zoom_dir = ptcq_pkg::DIR_STOP;
						default: ;
					endcase
					issue_expect.push_back(e);
				end
			end
			ptcq_pkg::ACT_MANUAL: begin
				if (mc <= ptcq_pkg::CMD_HOME) begin
					if (ms > ptcq_pkg::SPEED_MAX)
						ms = ptcq_pkg::SPEED_MAX;
					if (mc != ptcq_pkg::CMD_PAN_STOP && mc != ptcq_pkg::CMD_TILT_STOP &&
							mc != ptcq_pkg::CMD_ZOOM_STOP && mc != ptcq_pkg::CMD_PRESET)
						halt_all();
					ring_push(mc, ms);
				end
			end
			default: halt_all();
		endcase
	endfunction

	always @(posedge clk) begin
		in_xfer <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			predict_item(s_tuser, s_tdata);
	end

	// ---------------- driver, sink, monitor ----------------

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_xfer)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				send_gap <= $urandom_range(0, 9);
				s_tvalid <= 1'b0;
			end else if (send_fifo.size() != 0) begin
				nxt_item = send_fifo.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= nxt_item.act;
				s_tdata <= nxt_item.data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_gap > 0) begin
				stall_gap <= stall_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_gap <= $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (issue_expect.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected command transfer: cmd %0d spd %0d",
						m_tdata[3:0], m_tdata[7:4]);
			end else begin
				want = issue_expect.pop_front();
				if (m_tdata[3:0] !== want.cmd || m_tdata[7:4] !== want.spd) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("command mismatch: got cmd %0d spd %0d, want cmd %0d spd %0d",
							m_tdata[3:0], m_tdata[7:4], want.cmd, want.spd);
				end
			end
		end
	end

	// no transfer on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------

	function automatic item_t mk_item(logic [1:0] act, logic [11:0] x, logic [11:0] y,
			logic [3:0] mc, logic [3:0] ms);
		return '{act: act, data: {ms, mc, y, x}};
	endfunction

	function automatic item_t mk_rand(logic [1:0] act);
		return mk_item(act, 12'($urandom), 12'($urandom), 4'($urandom), 4'($urandom));
	endfunction

	// position biased toward the still band and its edges
	function automatic logic [11:0] pick_pos(int ctr);
		int off, p, dz;
		dz = int'(dz_r);
		off = 0;
		case ($urandom_range(0, 4))
			0: return 12'($urandom);
			1: off = $urandom_range(0, dz);
			2: off = dz + $urandom_range(0, 1);
			default: off = dz + 1 + $urandom_range(0, 300);
		endcase
		p = ($urandom_range(0, 1) != 0) ? ctr + off : ctr - off;
		if (p < 0)
			p = 0;
		if (p > 4095)
			p = 4095;
		return 12'(p);
	endfunction

	task automatic cfg_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	task automatic write_cfg(logic [11:0] cx, logic [11:0] cy, logic [11:0] dz,
			logic [3:0] lv, logic [15:0] iv);
		cfg_reg(ptcq_pkg::REG_CENTER_X, {4'd0, cx});
		cfg_reg(ptcq_pkg::REG_CENTER_Y, {4'd0, cy});
		cfg_reg(ptcq_pkg::REG_DEAD_ZONE, {4'd0, dz});
		cfg_reg(ptcq_pkg::REG_SPEED_LEVELS, {12'd0, lv});
		cfg_reg(ptcq_pkg::REG_ISSUE_INTERVAL, iv);
		@(negedge clk);
		cfg_we <= 1'b0;
		cx_r = cx;
		cy_r = cy;
		dz_r = dz;
		lv_r = lv;
		iv_r = iv;
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (send_fifo.size() != 0 || s_tvalid);
	endtask

	// tick the ring empty, then wait for the last issued command
	task automatic drain_all();
		settle();
		while (rd_ptr != wr_ptr) begin
			repeat (32)
				send_fifo.push_back(mk_rand(ptcq_pkg::ACT_TICK));
			settle();
		end
		while (issue_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic run_random(int n);
		int left, r, k;
		item_t last_track;
		left = n;
		last_track = mk_item(ptcq_pkg::ACT_TRACK, cx_r, cy_r, 4'd0, 4'd0);
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				// a repeated sample must not queue anything new
				if ($urandom_range(0, 3) != 0)
					last_track = mk_item(ptcq_pkg::ACT_TRACK, pick_pos(int'(cx_r)),
						pick_pos(int'(cy_r)), 4'($urandom), 4'($urandom));
				send_fifo.push_back(last_track);
				left--;
			end else if (r < 80) begin
				send_fifo.push_back(mk_rand(ptcq_pkg::ACT_TICK));
				left--;
			end else if (r < 92) begin
				send_fifo.push_back(mk_rand(ptcq_pkg::ACT_MANUAL));
				left--;
			end else if (r < 95) begin
				send_fifo.push_back(mk_rand(ptcq_pkg::ACT_STOP));
				left--;
			end else begin
				// run of presets that can overflow the ring
				k = $urandom_range(14, 22);
				repeat (k)
					send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'($urandom),
						12'($urandom), ptcq_pkg::CMD_PRESET, 4'($urandom)));
				left -= k;
			end
		end
	endtask

	initial begin
		cx_r = 12'd320;
		cy_r = 12'd240;
		dz_r = 12'd40;
		lv_r = 4'd7;
		iv_r = 16'd100;
		rd_ptr = '0;
		wr_ptr = '0;
		pan_req = ptcq_pkg::DIR_STOP;
		tilt_req = ptcq_pkg::DIR_STOP;
		pan_last = '0;
		tilt_last = '0;
		pan_dir = ptcq_pkg::DIR_STOP;
		tilt_dir = ptcq_pkg::DIR_STOP;
		zoom_dir = ptcq_pkg::DIR_STOP;
		tick_cnt = '0;

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset configuration
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TRACK, 12'd320, 12'd240, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TRACK, 12'd4095, 12'd0, 4'd15, 4'd15));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TRACK, 12'd4095, 12'd0, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TRACK, 12'd400, 12'd300, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TRACK, 12'd361, 12'd281, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TRACK, 12'd360, 12'd280, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TRACK, 12'd0, 12'd4095, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_TICK, 12'd0, 12'd0, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_TELE, 4'd15));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0, 4'd11, 4'd3));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0, 4'd15, 4'd3));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_PAN_STOP, 4'd3));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_PRESET, 4'd9));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_HOME, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_WIDE, 4'd12));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_STOP, 12'd0, 12'd0, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_PAN_LEFT, 4'd5));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_TILT_UP, 4'd9));
		drain_all();

		write_cfg(12'd320, 12'd240, 12'd40, 4'd7, 16'd2);
		// tilt now moving: a stop request must stop it
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_STOP, 12'd4095, 12'd4095, 4'd15, 4'd15));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_TELE, 4'd2));
		drain_all();
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_TILT_STOP, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_STOP, 12'd0, 12'd0, 4'd0, 4'd0));
		send_fifo.push_back(mk_item(ptcq_pkg::ACT_MANUAL, 12'd0, 12'd0,
			ptcq_pkg::CMD_ZOOM_STOP, 4'd7));
		drain_all();

		run_random(80);
		drain_all();
		write_cfg(12'd2048, 12'd2048, 12'd100, 4'd9, 16'd0);
		run_random(80);
		drain_all();
		write_cfg(12'd0, 12'd4095, 12'd0, 4'd1, 16'd1);
		run_random(80);
		drain_all();
		write_cfg(12'd4095, 12'd0, 12'd4095, 4'd15, 16'd3);
		run_random(80);
		drain_all();
		write_cfg(12'd100, 12'd3000, 12'd50, 4'd0, 16'd0);
		run_random(80);
		drain_all();
		write_cfg(12'($urandom), 12'($urandom), 12'($urandom), 4'($urandom),
			16'($urandom_range(0, 6)));
		run_random(80);
		drain_all();

		// last part runs without idling on either side
		calm = 1'b1;
		write_cfg(12'd640, 12'd480, 12'd20, 4'd12, 16'd1);
		run_random(80);
		drain_all();

		if (n_mismatch == 0 && issue_expect.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
